// ----- sv/wsfr_pkg.sv -----
// Shared types, codes and constants of the frame receiver.
package wsfr_pkg;

    localparam int LEN_W = 27;
    localparam int QDEPTH = 3;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(64 << 20);

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [15:0] CODE_NONE     = 16'd1005;
    localparam logic [15:0] CODE_ABNORMAL = 16'd1006;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_ABORT  = 3'd1,
        KIND_PONG   = 3'd2,
        KIND_REASON = 3'd3,
        KIND_CLOSE  = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_PAY
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        is_text;
        logic        last;
        logic        in_fragmented;
        logic [15:0] close_code;
    } t_result;

    typedef struct packed {
        logic [1:0]        cnt;
        t_result [1:0]     res;
    } t_push;

    function automatic t_result mk_result(t_kind kind, logic [7:0] data_byte,
                                          logic has_data, logic is_text, logic last,
                                          logic in_fragmented, logic [15:0] close_code);
        t_result r;
        r.kind          = kind;
        r.data_byte     = data_byte;
        r.has_data      = has_data;
        r.is_text       = is_text;
        r.last          = last;
        r.in_fragmented = in_fragmented;
        r.close_code    = close_code;
        return r;
    endfunction

endpackage

// ----- sv/wsfr_result_queue.sv -----
// Three-entry result queue that takes up to two results at once and drains one per cycle while the consumer pops.
module wsfr_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsfr_pkg::t_push   i_push,
    input  logic              i_pop,
    output wsfr_pkg::t_result o_head,
    output logic              o_valid,
    output logic              o_room
);
    import wsfr_pkg::*;

    t_result [QDEPTH-1:0] r_slot;
    t_result [QDEPTH-1:0] n_slot;
    logic [QCNT_W-1:0]    r_cnt;
    logic [QCNT_W-1:0]    n_cnt;
    logic [QCNT_W-1:0]    cnt_p;
    logic                 pop_eff;

    always_comb begin
        pop_eff = i_pop && (r_cnt != '0);
        cnt_p   = r_cnt - QCNT_W'(pop_eff);
        n_slot  = r_slot;
        for (int k = 0; k < QDEPTH - 1; k++) begin
            if (pop_eff) begin
                n_slot[k] = r_slot[k+1];
            end
        end
        for (int k = 0; k < QDEPTH; k++) begin
            if (i_push.cnt != 2'd0 && cnt_p == QCNT_W'(k)) begin
                n_slot[k] = i_push.res[0];
            end
            if (i_push.cnt == 2'd2 && cnt_p + QCNT_W'(1) == QCNT_W'(k)) begin
                n_slot[k] = i_push.res[1];
            end
        end
        n_cnt = cnt_p + QCNT_W'(i_push.cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_head  = r_slot[0];
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCNT_W'(1));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_cnt <= QCNT_W'(1)))
        else $error("Results pushed into a queue without room for two.");

    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && !i_pop) |=> $stable(r_slot[0]))
        else $error("Queue head changed while it was not taken.");

endmodule

// ----- sv/wsfr_parser.sv -----
// Frame header and payload parser that turns one accepted item into up to two results.
module wsfr_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_rx_byte,
    input  logic [wsfr_pkg::LEN_W-1:0]   i_max_len,
    output wsfr_pkg::t_push              o_push
);
    import wsfr_pkg::*;

    t_phase           r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_op, n_op;
    logic [2:0]       r_ext_cnt, n_ext_cnt;
    logic [LEN_W-1:0] r_ext_len, n_ext_len;
    logic             r_big, n_big;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [1:0]       r_pidx, n_pidx;
    logic [15:0]      r_code, n_code;
    logic             r_asm, n_asm;
    logic             r_asm_text, n_asm_text;
    logic             r_done, n_done;

    t_push            push;
    logic [1:0]       k;
    logic             begin_now;
    logic             fatal_now;
    logic [LEN_W-1:0] len_v;
    logic             big_v;
    logic [LEN_W-1:0] ext_acc;
    logic             ext_big;
    logic             is_data;
    logic             empty;
    logic             text_v;
    logic             frag_v;
    logic             lastb;
    logic [1:0]       pidx_v;
    logic [15:0]      code_v;

    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_op       = r_op;
        n_ext_cnt  = r_ext_cnt;
        n_ext_len  = r_ext_len;
        n_big      = r_big;
        n_rem      = r_rem;
        n_pidx     = r_pidx;
        n_code     = r_code;
        n_asm      = r_asm;
        n_asm_text = r_asm_text;
        n_done     = r_done;
        push       = '0;
        k          = 2'd0;
        begin_now  = 1'b0;
        fatal_now  = 1'b0;
        len_v      = '0;
        big_v      = 1'b0;
        ext_acc    = {r_ext_len[LEN_W-9:0], i_rx_byte};
        ext_big    = r_big | (r_ext_len[LEN_W-1:LEN_W-8] != 8'd0);
        is_data    = (r_op == OP_CONT) || (r_op == OP_TEXT) || (r_op == OP_BIN);
        text_v     = (r_op == OP_CONT) ? r_asm_text : (r_op == OP_TEXT);
        frag_v     = (r_op == OP_CONT) || !r_fin;
        empty      = 1'b0;
        lastb      = (r_rem == LEN_W'(1));
        pidx_v     = r_pidx;
        code_v     = r_code;

        if (i_accept && !r_done) begin
            if (i_req_type) begin
                fatal_now = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HDR0: begin
                        n_fin   = i_rx_byte[7];
                        n_op    = i_rx_byte[3:0];
                        n_phase = PH_HDR1;
                    end
                    PH_HDR1: begin
                        if (i_rx_byte[7]) begin
                            fatal_now = 1'b1;
                        end else if (i_rx_byte[6:0] == LEN7_EXT16 ||
                                     i_rx_byte[6:0] == LEN7_EXT64) begin
                            n_ext_cnt = (i_rx_byte[6:0] == LEN7_EXT64) ? 3'd7 : 3'd1;
                            n_ext_len = '0;
                            n_big     = 1'b0;
                            n_phase   = PH_EXT;
                        end else begin
                            begin_now = 1'b1;
                            len_v     = LEN_W'(i_rx_byte[6:0]);
                        end
                    end
                    PH_EXT: begin
                        n_ext_len = ext_acc;
                        n_big     = ext_big;
                        if (r_ext_cnt == 3'd0) begin
                            begin_now = 1'b1;
                            len_v     = ext_acc;
                            big_v     = ext_big;
                        end else begin
                            n_ext_cnt = r_ext_cnt - 3'd1;
                        end
                    end
                    PH_PAY: begin
                        n_rem = r_rem - LEN_W'(1);
                        if (lastb) begin
                            n_phase = PH_HDR0;
                        end
                        if (is_data) begin
                            push.res[k[0]] = mk_result(KIND_DATA, i_rx_byte, 1'b1, text_v,
                                                       lastb && r_fin, frag_v, 16'd0);
                            k = k + 2'd1;
                            if (lastb && r_fin && r_op == OP_CONT) begin
                                n_asm      = 1'b0;
                                n_asm_text = 1'b0;
                            end
                        end else if (r_op == OP_PING) begin
                            push.res[k[0]] = mk_result(KIND_PONG, i_rx_byte, 1'b1, 1'b0,
                                                       lastb, 1'b0, 16'd0);
                            k = k + 2'd1;
                        end else if (r_op == OP_CLOSE) begin
                            if (r_pidx < 2'd2) begin
                                code_v = {r_code[7:0], i_rx_byte};
                                pidx_v = r_pidx + 2'd1;
                            end else begin
                                push.res[k[0]] = mk_result(KIND_REASON, i_rx_byte, 1'b1,
                                                           1'b0, 1'b0, 1'b0, 16'd0);
                                k = k + 2'd1;
                            end
                            n_pidx = pidx_v;
                            n_code = code_v;
                            if (lastb) begin
                                push.res[k[0]] = mk_result(KIND_CLOSE, 8'd0, 1'b0, 1'b0,
                                    1'b0, 1'b0, (pidx_v == 2'd2) ? code_v : CODE_NONE);
                                k      = k + 2'd1;
                                n_done = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        if (begin_now) begin
            empty = (len_v == '0);
            if (big_v || len_v > i_max_len) begin
                fatal_now = 1'b1;
            end else begin
                n_phase = empty ? PH_HDR0 : PH_PAY;
                n_rem   = len_v;
                if (is_data) begin
                    if (r_op != OP_CONT && !r_fin) begin
                        if (r_asm) begin
                            push.res[k[0]] = mk_result(KIND_ABORT, 8'd0, 1'b0, r_asm_text,
                                                       1'b0, 1'b1, 16'd0);
                            k = k + 2'd1;
                        end
                        n_asm      = 1'b1;
                        n_asm_text = (r_op == OP_TEXT);
                    end else if (r_op == OP_CONT) begin
                        n_asm = 1'b1;
                    end
                    if (empty && r_fin) begin
                        push.res[k[0]] = mk_result(KIND_DATA, 8'd0, 1'b0, text_v, 1'b1,
                                                   frag_v, 16'd0);
                        k = k + 2'd1;
                        if (r_op == OP_CONT) begin
                            n_asm      = 1'b0;
                            n_asm_text = 1'b0;
                        end
                    end
                end else if (r_op == OP_PING) begin
                    if (empty) begin
                        push.res[k[0]] = mk_result(KIND_PONG, 8'd0, 1'b0, 1'b0, 1'b1,
                                                   1'b0, 16'd0);
                        k = k + 2'd1;
                    end
                end else if (r_op == OP_CLOSE) begin
                    n_pidx = 2'd0;
                    n_code = 16'd0;
                    if (empty) begin
                        push.res[k[0]] = mk_result(KIND_CLOSE, 8'd0, 1'b0, 1'b0, 1'b0,
                                                   1'b0, CODE_NONE);
                        k      = k + 2'd1;
                        n_done = 1'b1;
                    end
                end
            end
        end

        if (fatal_now) begin
            push.res[0] = mk_result(KIND_ERROR, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
            push.res[1] = mk_result(KIND_CLOSE, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    CODE_ABNORMAL);
            k      = 2'd2;
            n_done = 1'b1;
        end
        push.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_fin      <= 1'b0;
            r_op       <= 4'd0;
            r_ext_cnt  <= 3'd0;
            r_ext_len  <= '0;
            r_big      <= 1'b0;
            r_rem      <= '0;
            r_pidx     <= 2'd0;
            r_code     <= 16'd0;
            r_asm      <= 1'b0;
            r_asm_text <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_fin      <= n_fin;
            r_op       <= n_op;
            r_ext_cnt  <= n_ext_cnt;
            r_ext_len  <= n_ext_len;
            r_big      <= n_big;
            r_rem      <= n_rem;
            r_pidx     <= n_pidx;
            r_code     <= n_code;
            r_asm      <= n_asm;
            r_asm_text <= n_asm_text;
            r_done     <= n_done;
        end
    end

    assign o_push = push;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("Parser left the halted state without a reset.");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (o_push.cnt == 2'd0))
        else $error("Halted parser produced a result.");

    a_pay_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_rem != '0))
        else $error("Payload phase entered with no bytes remaining.");

endmodule

// ----- sv/websocket_frame_receiver.sv -----
// Top level of the frame receiver: configuration register, parser and result queue.
// The receiver accepts one item per cycle as long as its result queue holds at most one
// result, and writes the results of an accepted item into the registered result queue.
// Most items give zero or one result; an error with its close event, and a final close
// reason byte with its close event, give two, which leave the three-entry result queue one
// at a time. The output rate of one result per cycle while the consumer is ready is what
// bounds throughput.
module websocket_frame_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wsfr_pkg::LEN_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_req_type,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_kind,
    output logic [7:0]                 o_data_byte,
    output logic                       o_has_data,
    output logic                       o_is_text,
    output logic                       o_last,
    output logic                       o_in_fragmented,
    output logic [15:0]                o_close_code
);
    import wsfr_pkg::*;

    logic [LEN_W-1:0] r_max_len;
    logic             accept;
    logic             room;
    t_push            push;
    t_result          head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    assign o_ready = room;
    assign accept  = i_valid && room;

    wsfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_max_len  (r_max_len),
        .o_push     (push)
    );

    wsfr_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_ready),
        .o_head  (head),
        .o_valid (o_valid),
        .o_room  (room)
    );

    assign o_kind          = head.kind;
    assign o_data_byte     = head.data_byte;
    assign o_has_data      = head.has_data;
    assign o_is_text       = head.is_text;
    assign o_last          = head.last;
    assign o_in_fragmented = head.in_fragmented;
    assign o_close_code    = head.close_code;

endmodule
